/* design/deq_pkg.sv */
package deq_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned REQ_W   = 40;
   localparam int unsigned RSP_W   = 40;

   typedef enum logic [1:0] {
      CMD_PUSH_REAR  = 2'd0,
      CMD_PUSH_FRONT = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_OVERFLOW  = 2'd1,
      STAT_UNDERFLOW = 2'd2
   } status_type;

   localparam logic [VALUE_W-1:0] NEG_ONE = '1;

   // outcome of one command, handed from the index logic to the pipeline
   typedef struct packed {
      status_type status;
      logic       pop_hit;
   } deq_res_type;

endpackage

/* design/deq_ram.sv */
module deq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/deq_ctrl.sv */
module deq_ctrl #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  deq_pkg::cmd_type             command,
   input  logic [deq_pkg::VALUE_W-1:0]  push_value,
   output logic                         wr_en,
   output logic [$clog2(DEPTH)-1:0]     wr_addr,
   output logic [deq_pkg::VALUE_W-1:0]  wr_data,
   output logic                         rd_en,
   output logic [$clog2(DEPTH)-1:0]     rd_addr,
   output deq_pkg::deq_res_type         res
);

   import deq_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned IW = AW + 1;
   localparam logic signed [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic signed [IW-1:0] MINUS_ONE = '1;
   localparam logic signed [IW-1:0] ONE = IW'(1);

   // front points one slot before the first element, rear at the last
   logic signed [IW-1:0] front_ff, front_in;
   logic signed [IW-1:0] rear_ff, rear_in;
   logic signed [IW-1:0] front_inc, rear_inc;
   logic                 empty;

   assign empty     = (front_ff == rear_ff);
   assign front_inc = front_ff + ONE;
   assign rear_inc  = rear_ff + ONE;
   assign wr_data   = push_value;

   always_comb begin
      front_in    = front_ff;
      rear_in     = rear_ff;
      wr_en       = 1'b0;
      wr_addr     = rear_inc[AW-1:0];
      rd_en       = 1'b0;
      rd_addr     = front_inc[AW-1:0];
      res.status  = STAT_OK;
      res.pop_hit = 1'b0;
      case (command)
         CMD_PUSH_REAR: begin
            if (rear_ff == LAST_IDX) begin
               res.status = STAT_OVERFLOW;
            end else begin
               rear_in = rear_inc;
               wr_en   = fire;
               wr_addr = rear_inc[AW-1:0];
            end
         end
         CMD_PUSH_FRONT: begin
            if (front_ff == MINUS_ONE) begin
               res.status = STAT_OVERFLOW;
            end else begin
               front_in = front_ff - ONE;
               wr_en    = fire;
               wr_addr  = front_ff[AW-1:0];
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               res.status = STAT_UNDERFLOW;
            end else begin
               front_in    = front_inc;
               rd_en       = fire;
               rd_addr     = front_inc[AW-1:0];
               res.pop_hit = 1'b1;
            end
         end
         CMD_POP_REAR: begin
            if (empty) begin
               res.status = STAT_UNDERFLOW;
            end else begin
               rear_in     = rear_ff - ONE;
               rd_en       = fire;
               rd_addr     = rear_ff[AW-1:0];
               res.pop_hit = 1'b1;
            end
         end
         default: begin
            res.status = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
      end else if (fire) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
   end

endmodule

/* design/array_double_ended_queue.sv */
// Double-ended queue over a linear (non-circular) array of DEPTH words.
// req channel: one word per command; tdata carries command in [1:0]
// (0 push rear, 1 push front, 2 pop front, 3 pop rear) and the push value
// in [33:2]. rsp channel: one word per command; tdata carries the popped
// value in [31:0] (-1 for pushes and underflows) and status in [33:32]
// (0 ok, 1 overflow, 2 underflow).
// The indices are updated and the array accessed in the accepting cycle;
// the synchronous read result and the status are held in the middle
// stage, then move to the response register when it is free. One
// command is accepted every cycle while rsp_tready is high.
// When the receiver stalls, a response is held in the output register and
// one more in the middle stage; req_tready then drops until space frees.
// Reset (synchronous) empties the queue with both indices at slot zero
// and drops anything in flight; the array contents are left as they are.
module array_double_ended_queue #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [deq_pkg::REQ_W-1:0]   req_tdata,  // command, push_value
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [deq_pkg::RSP_W-1:0]   rsp_tdata   // pop_value, status
);

   import deq_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   logic                 req_fire;
   cmd_type              command;
   logic [VALUE_W-1:0]   push_value;
   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [VALUE_W-1:0]   wr_data, rd_data;
   deq_res_type          res;

   logic                 mid_valid_ff;
   deq_res_type          mid_res_ff;
   logic                 out_valid_ff;
   logic [VALUE_W-1:0]   out_value_ff;
   status_type           out_status_ff;
   logic                 out_free, mid_move;

   assign command    = cmd_type'(req_tdata[1:0]);
   assign push_value = req_tdata[VALUE_W+1:2];

   assign out_free   = !out_valid_ff || rsp_tready;
   assign mid_move   = mid_valid_ff && out_free;
   assign req_tready = !mid_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_fire),
      .command    (command),
      .push_value (push_value),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .res        (res)
   );

   // read data stays put until the next pop is issued, which cannot
   // happen while the middle stage is stuck
   deq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            mid_valid_ff <= 1'b1;
         end else if (mid_move) begin
            mid_valid_ff <= 1'b0;
         end
         if (mid_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mid_res_ff <= res;
      end
      if (mid_move) begin
         out_value_ff  <= mid_res_ff.pop_hit ? rd_data : NEG_ONE;
         out_status_ff <= mid_res_ff.status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W - VALUE_W - 2){1'b0}}, out_status_ff, out_value_ff};

endmodule
